// ----- design/tccw_pkg.sv -----
package tccw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;
    localparam int TAB_STEP        = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam int OP_W     = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = 16;

    localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_READ   = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF        = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR        = 8'h0D;
    localparam logic [CHAR_W-1:0] SPACE_CODE     = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_LAST     = 8'h7F;

    localparam logic [ATTR_W-1:0] BLANK_ATTR_RESET = 8'd15;
    localparam logic [ATTR_W-1:0] ERASE_ATTR       = 8'd0;

    typedef enum logic [3:0] {
        CMD_PRINT     = 4'd0,
        CMD_BACKSPACE = 4'd1,
        CMD_TAB       = 4'd2,
        CMD_CR        = 4'd3,
        CMD_LF        = 4'd4,
        CMD_NOP       = 4'd5,
        CMD_REMOVE    = 4'd6,
        CMD_CLEAR     = 4'd7,
        CMD_READ      = 4'd8
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [CHAR_W-1:0]  char_code;
        logic [ATTR_W-1:0]  color;
        logic [INDEX_W-1:0] cell_index;
    } cmd_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

endpackage

// ----- design/text_console_cell_writer_unit.sv -----
// Text console cell writer with a ROWS by COLUMNS screen store in one single-port-write memory.
// Items enter a two-item queue, so up to two items are still taken while the back end works
// or while a result waits in the output register. In the back end a put, a remove or an
// ignored byte is handled in the idle state, a read goes through a read state because the
// memory read is registered, and a clear or a put that scrolls sweeps the memory one cell per
// cycle through its one write port. After reset a sweep fills the screen with blank cells,
// and no item is accepted until it ends.
module text_console_cell_writer_unit import tccw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [ATTR_W-1:0]   cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [CHAR_W-1:0]   s_char_code,
    input  logic [ATTR_W-1:0]   s_color,
    input  logic [INDEX_W-1:0]  s_cell_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CURSOR_W-1:0] m_cursor_location,
    output logic [CELL_W-1:0]   m_cell_data
);

    cmd_t         cmd;
    logic         cmd_valid;
    logic         cmd_ready;
    back_status_t status;

    tccw_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_char_code  (s_char_code),
        .s_color      (s_color),
        .s_cell_index (s_cell_index),
        .status       (status),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd)
    );

    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd_valid         (cmd_valid),
        .cmd_ready         (cmd_ready),
        .cmd               (cmd),
        .status            (status),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cursor_location (m_cursor_location),
        .m_cell_data       (m_cell_data)
    );

endmodule

// ----- design/tccw_front.sv -----
module tccw_front import tccw_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [CHAR_W-1:0]   s_char_code,
    input  logic [ATTR_W-1:0]   s_color,
    input  logic [INDEX_W-1:0]  s_cell_index,
    input  back_status_t        status,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output cmd_t                cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cmd_t             new_cmd;
    logic             push;
    logic             pop;

    always_comb begin
        new_cmd.char_code  = s_char_code;
        new_cmd.color      = s_color;
        new_cmd.cell_index = s_cell_index;
        new_cmd.kind       = CMD_NOP;
        unique case (s_operation)
            OP_PUT: begin
                case (s_char_code)
                    CHAR_BACKSPACE: new_cmd.kind = CMD_BACKSPACE;
                    CHAR_TAB:       new_cmd.kind = CMD_TAB;
                    CHAR_CR:        new_cmd.kind = CMD_CR;
                    CHAR_LF:        new_cmd.kind = CMD_LF;
                    default: begin
                        if (s_char_code >= SPACE_CODE && s_char_code <= PRINT_LAST) begin
                            new_cmd.kind = CMD_PRINT;
                        end
                    end
                endcase
            end
            OP_REMOVE: new_cmd.kind = CMD_REMOVE;
            OP_CLEAR:  new_cmd.kind = CMD_CLEAR;
            OP_READ:   new_cmd.kind = CMD_READ;
            default:   new_cmd.kind = CMD_NOP;
        endcase
    end

    assign s_ready   = (count_reg != CNT_W'(QUEUE_DEPTH)) && !status.init_busy;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ----- design/tccw_back.sv -----
module tccw_back import tccw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  cmd_t                cmd,
    output back_status_t        status,
    input  logic                cfg_wr_en,
    input  logic [ATTR_W-1:0]   cfg_wr_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CURSOR_W-1:0] m_cursor_location,
    output logic [CELL_W-1:0]   m_cell_data
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int RW         = $clog2(ROWS);
    localparam int CLW        = $clog2(COLUMNS);
    localparam int CW1        = $clog2(COLUMNS + TAB_STEP);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    logic [CELL_W-1:0] mem [CELL_COUNT];

    state_t              state_reg, state_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [CLW-1:0]      col_reg, col_next;
    logic [AW-1:0]       cnt_reg, cnt_next;
    logic                scroll_reg, scroll_next;
    logic                init_reg, init_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [AW-1:0]       pend_addr_reg, pend_addr_next;
    logic                pend_blank_reg, pend_blank_next;
    logic                rd_oob_reg, rd_oob_next;
    logic [CELL_W-1:0]   rd_data_reg;
    logic                m_valid_reg, m_valid_next;
    logic [CURSOR_W-1:0] m_loc_reg, m_loc_next;
    logic [CELL_W-1:0]   m_data_reg, m_data_next;
    logic [ATTR_W-1:0]   blank_attr_reg;

    logic                out_free;
    logic [AW-1:0]       src_addr;
    logic [AW-1:0]       mem_raddr;
    logic                imm_we;
    logic [AW-1:0]       imm_addr;
    logic [CELL_W-1:0]   imm_data;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic [CELL_W-1:0]   blank_cell;

    logic [CW1-1:0]      put_col_w;
    logic                put_row_inc;
    logic                put_we;
    logic                put_scroll;
    logic [CLW-1:0]      put_col;
    logic [RW-1:0]       put_row;
    logic [RW-1:0]       rem_row;
    logic [CLW-1:0]      rem_col;
    logic                rem_home;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                input logic [CLW-1:0] col);
        cell_addr = AW'(32'(row) * COLUMNS + 32'(col));
    endfunction

    assign out_free          = !m_valid_reg || m_ready;
    assign status.init_busy  = init_reg;
    assign m_valid           = m_valid_reg;
    assign m_cursor_location = m_loc_reg;
    assign m_cell_data       = m_data_reg;
    assign src_addr          = AW'(32'(cnt_reg) + COLUMNS);
    assign blank_cell        = {(init_reg ? BLANK_ATTR_RESET : blank_attr_reg), SPACE_CODE};

    always_comb begin
        put_col_w   = CW1'(col_reg);
        put_row_inc = 1'b0;
        put_we      = 1'b0;
        case (cmd.kind)
            CMD_BACKSPACE: begin
                if (col_reg != '0) begin
                    put_col_w = put_col_w - 1'b1;
                end
            end
            CMD_TAB:   put_col_w = (put_col_w + CW1'(TAB_STEP)) & ~CW1'(TAB_STEP - 1);
            CMD_CR:    put_col_w = '0;
            CMD_LF: begin
                put_col_w   = '0;
                put_row_inc = 1'b1;
            end
            CMD_PRINT: begin
                put_we    = 1'b1;
                put_col_w = put_col_w + 1'b1;
            end
            default: ;
        endcase
        if (put_col_w >= CW1'(COLUMNS)) begin
            put_col_w   = '0;
            put_row_inc = 1'b1;
        end
        put_col    = CLW'(put_col_w);
        put_scroll = put_row_inc && (row_reg == RW'(ROWS - 1));
        put_row    = (put_row_inc && !put_scroll) ? row_reg + 1'b1 : row_reg;
    end

    always_comb begin
        rem_home = (row_reg == '0) && (col_reg == '0);
        rem_row  = row_reg;
        rem_col  = col_reg - 1'b1;
        if (col_reg == '0) begin
            rem_row = row_reg - 1'b1;
            rem_col = CLW'(COLUMNS - 1);
        end
    end

    always_comb begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        cnt_next        = cnt_reg;
        scroll_next     = scroll_reg;
        init_next       = init_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = cnt_reg;
        pend_blank_next = 1'b1;
        rd_oob_next     = rd_oob_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_loc_next      = m_loc_reg;
        m_data_next     = m_data_reg;
        imm_we          = 1'b0;
        imm_addr        = cell_addr(row_reg, col_reg);
        imm_data        = {ERASE_ATTR, SPACE_CODE};
        mem_raddr       = src_addr;
        cmd_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_ready = 1'b1;
                    unique case (cmd.kind)
                        CMD_REMOVE: begin
                            if (!rem_home) begin
                                row_next = rem_row;
                                col_next = rem_col;
                                imm_we   = 1'b1;
                                imm_addr = cell_addr(rem_row, rem_col);
                            end
                            m_valid_next = 1'b1;
                            m_data_next  = '0;
                            m_loc_next   = rem_home ? '0 :
                                           CURSOR_W'(cell_addr(rem_row, rem_col));
                        end
                        CMD_CLEAR: begin
                            row_next    = '0;
                            col_next    = '0;
                            cnt_next    = '0;
                            scroll_next = 1'b0;
                            state_next  = ST_SWEEP;
                        end
                        CMD_READ: begin
                            mem_raddr   = AW'(cmd.cell_index);
                            rd_oob_next = !(32'(cmd.cell_index) < CELL_COUNT);
                            state_next  = ST_READ;
                        end
                        CMD_PRINT, CMD_BACKSPACE, CMD_TAB, CMD_CR, CMD_LF, CMD_NOP: begin
                            row_next = put_row;
                            col_next = put_col;
                            imm_we   = put_we;
                            imm_data = {cmd.color, cmd.char_code};
                            if (put_scroll) begin
                                cnt_next    = '0;
                                scroll_next = 1'b1;
                                state_next  = ST_SWEEP;
                            end else begin
                                m_valid_next = 1'b1;
                                m_data_next  = '0;
                                m_loc_next   = CURSOR_W'(cell_addr(put_row, put_col));
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                m_valid_next = 1'b1;
                m_loc_next   = CURSOR_W'(cell_addr(row_reg, col_reg));
                m_data_next  = rd_oob_reg ? '0 : rd_data_reg;
                state_next   = ST_IDLE;
            end
            ST_SWEEP: begin
                pend_valid_next = 1'b1;
                pend_addr_next  = cnt_reg;
                pend_blank_next = !scroll_reg || (32'(cnt_reg) >= CELL_COUNT - COLUMNS);
                if (cnt_reg == AW'(CELL_COUNT - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                init_next = 1'b0;
                if (!init_reg) begin
                    m_valid_next = 1'b1;
                    m_loc_next   = CURSOR_W'(cell_addr(row_reg, col_reg));
                    m_data_next  = '0;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign mem_we    = pend_valid_reg || imm_we;
    assign mem_waddr = pend_valid_reg ? pend_addr_reg : imm_addr;
    assign mem_wdata = pend_valid_reg ? (pend_blank_reg ? blank_cell : rd_data_reg) : imm_data;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            row_reg        <= '0;
            col_reg        <= '0;
            cnt_reg        <= '0;
            scroll_reg     <= 1'b0;
            init_reg       <= 1'b1;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            blank_attr_reg <= BLANK_ATTR_RESET;
        end else begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            cnt_reg        <= cnt_next;
            scroll_reg     <= scroll_next;
            init_reg       <= init_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                blank_attr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg  <= pend_addr_next;
        pend_blank_reg <= pend_blank_next;
        rd_oob_reg     <= rd_oob_next;
        m_loc_reg      <= m_loc_next;
        m_data_reg     <= m_data_next;
    end

endmodule

// ----- design/tccw_checker.sv -----
module tccw_checker import tccw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                cfg_wr_en,
    input logic [ATTR_W-1:0]   cfg_wr_data,
    input logic                s_valid,
    input logic                s_ready,
    input logic [OP_W-1:0]     s_operation,
    input logic [CHAR_W-1:0]   s_char_code,
    input logic [ATTR_W-1:0]   s_color,
    input logic [INDEX_W-1:0]  s_cell_index,
    input logic                m_valid,
    input logic                m_ready,
    input logic [CURSOR_W-1:0] m_cursor_location,
    input logic [CELL_W-1:0]   m_cell_data
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int MAX_OPEN   = QUEUE_DEPTH + 1;

    logic [2:0] open_reg;
    logic       in_take;
    logic       out_take;
    logic       unused_inputs;

    assign in_take       = s_valid && s_ready;
    assign out_take      = m_valid && m_ready;
    assign unused_inputs = ^{cfg_wr_en, cfg_wr_data, s_operation, s_char_code, s_color,
                             s_cell_index};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else if (in_take && !out_take) begin
            open_reg <= open_reg + 1'b1;
        end else if (out_take && !in_take) begin
            open_reg <= open_reg - 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cursor_location) && $stable(m_cell_data))
        else $error("result changed while stalled");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (CELL_COUNT > 2048) || (32'(m_cursor_location) < CELL_COUNT))
        else $error("cursor location outside the screen");

    a_no_extra_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> open_reg != '0)
        else $error("result without an accepted item");

    a_open_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(open_reg) <= MAX_OPEN || unused_inputs != unused_inputs)
        else $error("more items in flight than the queue can hold");

    a_reset_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready during the reset clearing pass");

endmodule

bind text_console_cell_writer_unit tccw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_checker (.*);

// ----- bench/text_console_cell_writer_unit_tb.sv -----
module text_console_cell_writer_unit_tb;
    import tccw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_COLS      = COLUMNS_DEFAULT;
    localparam int SCREEN_ROWS      = ROWS_DEFAULT;
    localparam int CELL_COUNT       = SCREEN_COLS * SCREEN_ROWS;
    localparam int ROW_W            = 5;
    localparam int COL_W            = 7;
    localparam int ITEMS_PER_PHASE  = 295;
    localparam int SETTLE_CYCLES    = CELL_COUNT + 16;
    localparam int LONG_HOLD        = 400;
    localparam int REPORT_LIMIT     = 10;

    typedef struct {
        logic [CURSOR_W-1:0] cursor;
        logic [CELL_W-1:0]   data;
    } console_reply_t;

    class console_shadow;
        logic [CELL_W-1:0] screen_mem [CELL_COUNT];
        logic [ROW_W-1:0]  cur_row;
        logic [COL_W-1:0]  cur_col;
        logic [ATTR_W-1:0] blank_attr;
        console_reply_t    pending_replies [$];
        int                mismatch_count;

        function new();
            blank_attr = BLANK_ATTR_RESET;
            mismatch_count = 0;
            clear_screen();
        endfunction

        function void set_blank_attr(logic [ATTR_W-1:0] value);
            blank_attr = value;
        endfunction

        function void clear_screen();
            foreach (screen_mem[i]) screen_mem[i] = {blank_attr, SPACE_CODE};
            cur_row = '0;
            cur_col = '0;
        endfunction

        // Moving past the last row shifts the screen up and blanks the bottom row.
        function void advance_row();
            cur_row++;
            if (cur_row >= SCREEN_ROWS) begin
                for (int i = 0; i < CELL_COUNT - SCREEN_COLS; i++)
                    screen_mem[i] = screen_mem[i + SCREEN_COLS];
                for (int i = CELL_COUNT - SCREEN_COLS; i < CELL_COUNT; i++)
                    screen_mem[i] = {blank_attr, SPACE_CODE};
                cur_row = ROW_W'(SCREEN_ROWS - 1);
            end
        endfunction

        function void put_char(logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] color);
            if (ch == CHAR_BACKSPACE) begin
                if (cur_col != 0)
                    cur_col--;
            end else if (ch == CHAR_TAB) begin
                cur_col = COL_W'((int'(cur_col) + TAB_STEP) & ~(TAB_STEP - 1));
            end else if (ch == CHAR_CR) begin
                cur_col = '0;
            end else if (ch == CHAR_LF) begin
                cur_col = '0;
                advance_row();
            end else if (ch >= SPACE_CODE && ch <= PRINT_LAST) begin
                screen_mem[int'(cur_row) * SCREEN_COLS + int'(cur_col)] = {color, ch};
                cur_col++;
            end
            if (cur_col >= SCREEN_COLS) begin
                cur_col = '0;
                advance_row();
            end
        endfunction

        function void remove_prev();
            if (cur_col == 0 && cur_row == 0)
                return;
            if (cur_col == 0) begin
                cur_row--;
                cur_col = COL_W'(SCREEN_COLS - 1);
            end else begin
                cur_col--;
            end
            screen_mem[int'(cur_row) * SCREEN_COLS + int'(cur_col)] = {ERASE_ATTR, SPACE_CODE};
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                logic [ATTR_W-1:0] color, logic [INDEX_W-1:0] idx);
            console_reply_t reply;
            reply.data = '0;
            case (op)
                OP_PUT: begin
                    put_char(ch, color);
                end
                OP_REMOVE: begin
                    remove_prev();
                end
                OP_CLEAR: begin
                    clear_screen();
                end
                OP_READ: begin
                    if (idx < CELL_COUNT)
                        reply.data = screen_mem[idx];
                end
            endcase
            reply.cursor = CURSOR_W'(int'(cur_row) * SCREEN_COLS + int'(cur_col));
            pending_replies.push_back(reply);
        endfunction

        function void check_item(logic [CURSOR_W-1:0] got_cursor, logic [CELL_W-1:0] got_data);
            console_reply_t want;
            if (pending_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected item: cursor %0d data %h", got_cursor, got_data);
                return;
            end
            want = pending_replies.pop_front();
            if (got_cursor !== want.cursor) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("cursor mismatch: expected %0d, got %0d", want.cursor, got_cursor);
            end
            if (got_data !== want.data) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("cell data mismatch: expected %h, got %h", want.data, got_data);
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [ATTR_W-1:0]   cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation = OP_PUT;
    logic [CHAR_W-1:0]   s_char_code = '0;
    logic [ATTR_W-1:0]   s_color = '0;
    logic [INDEX_W-1:0]  s_cell_index = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CURSOR_W-1:0] m_cursor_location;
    logic [CELL_W-1:0]   m_cell_data;

    console_shadow shadow = new();
    int burst_left = 0;
    int accepted_items = 0;

    text_console_cell_writer_unit u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_char_code       (s_char_code),
        .s_color           (s_color),
        .s_cell_index      (s_cell_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cursor_location (m_cursor_location),
        .m_cell_data       (m_cell_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(100_000_000);
        $display("simulation failed");
        $finish;
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                             input logic [ATTR_W-1:0] color, input logic [INDEX_W-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_char_code  <= ch;
        s_color      <= color;
        s_cell_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        shadow.note_item(op, ch, color, idx);
        accepted_items++;
        burst_left--;
    endtask

    // Mostly printable text with enough line feeds to reach the bottom rows and scroll.
    task automatic send_random_item();
        int pick;
        logic [OP_W-1:0]    op;
        logic [CHAR_W-1:0]  ch;
        logic [ATTR_W-1:0]  color;
        logic [INDEX_W-1:0] idx;
        ch    = CHAR_W'($urandom);
        color = ATTR_W'($urandom);
        idx   = INDEX_W'($urandom);
        pick  = $urandom_range(0, 99);
        if (pick < 78) begin
            op = OP_PUT;
            pick = $urandom_range(0, 99);
            if (pick < 62)
                ch = CHAR_W'($urandom_range(SPACE_CODE, PRINT_LAST));
            else if (pick < 74)
                ch = CHAR_LF;
            else if (pick < 80)
                ch = CHAR_TAB;
            else if (pick < 85)
                ch = CHAR_BACKSPACE;
            else if (pick < 89)
                ch = CHAR_CR;
        end else if (pick < 86) begin
            op = OP_REMOVE;
        end else if (pick < 99) begin
            op = OP_READ;
            if ($urandom_range(0, 9) != 0)
                idx = INDEX_W'($urandom_range(0, CELL_COUNT - 1));
        end else begin
            op = OP_CLEAR;
        end
        send_item(op, ch, color, idx);
    endtask

    task automatic finish_phase();
        s_valid <= 1'b0;
        burst_left = 0;
        while (shadow.pending_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_blank_attr(input logic [ATTR_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        shadow.set_blank_attr(value);
    endtask

    task automatic run_directed();
        send_item(OP_READ,   8'h00,          8'h00, 11'd0);
        send_item(OP_READ,   8'hFF,          8'hFF, 11'd1999);
        send_item(OP_READ,   8'h41,          8'h12, 11'h7FF);
        send_item(OP_REMOVE, 8'h41,          8'hFF, 11'd5);
        send_item(OP_PUT,    CHAR_BACKSPACE, 8'h00, 11'd0);
        send_item(OP_PUT,    8'h41,          8'hFF, 11'h7FF);
        send_item(OP_PUT,    PRINT_LAST,     8'h00, 11'd0);
        send_item(OP_PUT,    SPACE_CODE,     8'h5A, 11'd0);
        send_item(OP_PUT,    8'h1F,          8'h33, 11'd0);
        send_item(OP_PUT,    8'h80,          8'h33, 11'd0);
        send_item(OP_PUT,    8'hFF,          8'h33, 11'd0);
        send_item(OP_PUT,    8'h00,          8'h33, 11'd0);
        send_item(OP_PUT,    CHAR_BACKSPACE, 8'h33, 11'd0);
        send_item(OP_PUT,    CHAR_TAB,       8'h33, 11'd0);
        send_item(OP_PUT,    CHAR_CR,        8'h33, 11'd0);
        send_item(OP_PUT,    CHAR_LF,        8'h33, 11'd0);
        send_item(OP_REMOVE, 8'h00,          8'h00, 11'd0);
        send_item(OP_PUT,    8'h7A,          8'hC3, 11'd0);
        send_item(OP_REMOVE, 8'h00,          8'h00, 11'd0);
        send_item(OP_REMOVE, 8'h00,          8'h00, 11'd0);
        send_item(OP_READ,   8'h00,          8'h00, 11'd0);
        send_item(OP_READ,   8'h00,          8'h00, 11'd79);
        send_item(OP_CLEAR,  8'hFF,          8'hFF, 11'h7FF);
        send_item(OP_READ,   8'h00,          8'h00, 11'd0);
    endtask

    initial begin : stimulus
        logic [ATTR_W-1:0] phase_attr [4];
        phase_attr[0] = 8'h00;
        phase_attr[1] = 8'hFF;
        phase_attr[2] = ATTR_W'($urandom_range(1, 254));
        phase_attr[3] = 8'hA5;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        finish_phase();
        for (int p = 0; p < 4; p++) begin
            write_blank_attr(phase_attr[p]);
            repeat (ITEMS_PER_PHASE) send_random_item();
            finish_phase();
        end
        if (shadow.mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : result_sink
        int rx_cycle;
        int stall_mode;
        int holds_done;
        rx_cycle = 0;
        stall_mode = 0;
        holds_done = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                shadow.check_item(m_cursor_location, m_cell_data);
            rx_cycle++;
            if (rx_cycle % 200 == 0)
                stall_mode = $urandom_range(0, 3);
            // Hold the output long enough for the input queue to fill and back up.
            if ((holds_done == 0 && accepted_items >= 170) ||
                (holds_done == 1 && accepted_items >= 780)) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            case (stall_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_ready <= (rx_cycle % 5) != 0;
                end
                default: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

endmodule

// ----- sim.f -----
design/tccw_pkg.sv
design/tccw_front.sv
design/tccw_back.sv
design/text_console_cell_writer_unit.sv
design/tccw_checker.sv
bench/text_console_cell_writer_unit_tb.sv
